### rtl/arp_responder_cache_macros.svh
// Assertion macros shared by the ARP cache RTL.
// No dependencies; included by the files that check their own logic.
`ifndef ARP_RESPONDER_CACHE_MACROS_SVH
`define ARP_RESPONDER_CACHE_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define ARC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define ARC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define ARC_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define ARC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

### rtl/arc_pkg.sv
`timescale 1ns / 1ps
// Types and constants of the ARP cache and responder.
// No dependencies; used by the interfaces, the cell and the top level.
package arc_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
   localparam int STEP_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int IDX_W       = 5;
   localparam int CMP_W       = STEP_W + IDX_W;
   localparam int MAC_W       = 48;
   localparam int IP_W        = 32;

   // item modes
   localparam logic [1:0] MODE_RX      = 2'd0;
   localparam logic [1:0] MODE_LOOKUP  = 2'd1;
   localparam logic [1:0] MODE_WHO_HAS = 2'd2;
   localparam logic [1:0] MODE_READ    = 2'd3;

   // ARP opcodes, received and emitted
   localparam logic [15:0] ARP_OP_REQUEST   = 16'd1;
   localparam logic [15:0] ARP_OP_REPLY     = 16'd2;
   localparam logic [1:0]  FRAME_OP_REQUEST = 2'd1;
   localparam logic [1:0]  FRAME_OP_REPLY   = 2'd2;

   localparam logic [MAC_W-1:0] MAC_BROADCAST = '1;

   // register indexes
   localparam logic CSR_OWN_IP  = 1'b0;
   localparam logic CSR_OWN_MAC = 1'b1;

   typedef struct packed {
      logic [1:0]       mode;
      logic [15:0]      opcode;
      logic [MAC_W-1:0] sender_mac;
      logic [IP_W-1:0]  sender_ip;
      logic [IP_W-1:0]  target_ip;
      logic [IP_W-1:0]  query_ip;
      logic [IDX_W-1:0] entry_index;
   } req_word_type;

   typedef struct packed {
      logic             send_frame;
      logic [MAC_W-1:0] frame_dest_mac;
      logic [1:0]       frame_opcode;
      logic [MAC_W-1:0] frame_sender_mac;
      logic [IP_W-1:0]  frame_sender_ip;
      logic [MAC_W-1:0] frame_target_mac;
      logic [IP_W-1:0]  frame_target_ip;
      logic             found;
      logic [MAC_W-1:0] found_mac;
      logic [IP_W-1:0]  found_ip;
      logic [4:0]       entry_count;
      logic             table_full;
   } rsp_word_type;

   typedef struct packed {
      logic             index;
      logic [MAC_W-1:0] data;
   } csr_word_type;

   typedef struct packed {
      logic [IP_W-1:0]  ip;
      logic [MAC_W-1:0] mac;
   } cache_entry_type;

   // cell chain control: rotate toward cell 0, or shift in at cell 0
   typedef struct packed {
      logic rotate;
      logic insert;
   } cell_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

endpackage

### rtl/arc_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the ARP cache: request, response, CSR write.
// Depends on arc_pkg for the word types.
interface arc_req_if;
   logic                  valid;
   logic                  ready;
   arc_pkg::req_word_type word;
   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

interface arc_rsp_if;
   logic                  valid;
   logic                  ready;
   arc_pkg::rsp_word_type word;
   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

interface arc_csr_if;
   logic                  valid;
   logic                  ready;
   arc_pkg::csr_word_type word;
   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

### rtl/arc_cell.sv
`timescale 1ns / 1ps
// One cache slot of the cell chain: holds an IP/MAC pair.
// Depends on arc_pkg. Insert takes the left neighbor, rotate the right one.
module arc_cell (
   input  logic                     clock,
   input  arc_pkg::cell_ctl_type    ctl,
   input  arc_pkg::cache_entry_type from_left,
   input  arc_pkg::cache_entry_type from_right,
   output arc_pkg::cache_entry_type entry
);

   arc_pkg::cache_entry_type entry_ff;
   arc_pkg::cache_entry_type entry_in;

   always_comb begin
      priority if (ctl.insert) begin
         entry_in = from_left;
      end else if (ctl.rotate) begin
         entry_in = from_right;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

### rtl/arp_responder_cache.sv
`timescale 1ns / 1ps
// ARP responder with a cache of TABLE_DEPTH address pairs held in a chain of cells.
// Depends on arc_pkg, arc_if.sv (channels), arc_cell and the assertion macro header.
//
// One word is in work at a time. Requests addressed to own_ip, other received
// opcodes and who-has words need no cache access and go from the idle state
// straight to the done state. Lookups, indexed reads and received replies scan the
// cache: the cell chain rotates one place per cycle past cell 0, where the compare
// sits, for TABLE_DEPTH scan steps; after a
// full turn the chain is back in place. The cells store newest first (an insert
// shifts the chain right and writes cell 0), so at scan step t cell 0 holds
// entry t counted from the newest and is valid while t < entry count. IPs in the
// cache are unique, so the first compare hit is the only one. A reply whose IP
// is already cached leaves the cache alone; one that arrives with the table full
// is dropped and flagged in table_full. The response sits in an output register
// and is held until taken; the next word is accepted once the block is idle.
// CSR writes are always taken and must only come while the block is idle.
`include "arp_responder_cache_macros.svh"

module arp_responder_cache (
   input  logic      clock,
   input  logic      reset,
   arc_req_if.sink   req_bus,
   arc_rsp_if.source rsp_bus,
   arc_csr_if.sink   csr_bus
);

   localparam int DEPTH = arc_pkg::TABLE_DEPTH;

   // configuration
   logic [arc_pkg::IP_W-1:0]  own_ip_ff;
   logic [arc_pkg::MAC_W-1:0] own_mac_ff;

   // control
   arc_pkg::state_type               state_ff, state_in;
   logic [arc_pkg::STEP_W-1:0]       step_ff, step_in;
   logic [arc_pkg::COUNT_W-1:0]      count_ff, count_in;
   logic                             hit_ff, hit_in;
   logic                             rsp_valid_ff;

   // payload
   arc_pkg::req_word_type            item_ff;
   arc_pkg::cache_entry_type         hit_entry_ff;
   arc_pkg::rsp_word_type            rsp_word_ff, rsp_word_in;

   // cell chain
   arc_pkg::cache_entry_type         cells [DEPTH];
   arc_pkg::cache_entry_type         new_entry;
   arc_pkg::cell_ctl_type            cell_ctl;

   logic req_accept;
   logic rsp_load;
   logic needs_scan;
   logic last_step;
   logic head_valid;
   logic head_match;
   logic is_reply;
   logic do_insert;
   logic do_drop;
   logic [arc_pkg::IP_W-1:0] scan_key;

   // ---- configuration writes
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_ip_ff  <= '0;
         own_mac_ff <= '0;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.word.index)
            arc_pkg::CSR_OWN_IP:  own_ip_ff  <= csr_bus.word.data[arc_pkg::IP_W-1:0];
            arc_pkg::CSR_OWN_MAC: own_mac_ff <= csr_bus.word.data;
            default: ;
         endcase
      end
   end

   // ---- chain of cells
   assign new_entry = '{ip: item_ff.sender_ip, mac: item_ff.sender_mac};

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      arc_cell u_cell (
         .clock      (clock),
         .ctl        (cell_ctl),
         .from_left  ((i == 0) ? new_entry : cells[(i + DEPTH - 1) % DEPTH]),
         .from_right (cells[(i + 1) % DEPTH]),
         .entry      (cells[i])
      );
   end

   // ---- compare at the head cell
   assign is_reply   = (item_ff.mode == arc_pkg::MODE_RX) &&
                       (item_ff.opcode == arc_pkg::ARP_OP_REPLY);
   assign scan_key   = (item_ff.mode == arc_pkg::MODE_LOOKUP) ? item_ff.query_ip
                                                              : item_ff.sender_ip;
   assign head_valid = arc_pkg::COUNT_W'(step_ff) < count_ff;
   assign head_match = (item_ff.mode == arc_pkg::MODE_READ)
                     ? (arc_pkg::CMP_W'(step_ff) == arc_pkg::CMP_W'(item_ff.entry_index))
                     : (cells[0].ip == scan_key);
   assign last_step  = step_ff == arc_pkg::STEP_W'(DEPTH - 1);

   assign needs_scan = (req_bus.word.mode == arc_pkg::MODE_LOOKUP) ||
                       (req_bus.word.mode == arc_pkg::MODE_READ) ||
                       ((req_bus.word.mode == arc_pkg::MODE_RX) &&
                        (req_bus.word.opcode == arc_pkg::ARP_OP_REPLY));

   assign do_insert  = is_reply && !hit_ff && (count_ff < arc_pkg::COUNT_W'(DEPTH));
   assign do_drop    = is_reply && !hit_ff && (count_ff == arc_pkg::COUNT_W'(DEPTH));

   // ---- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         arc_pkg::ST_IDLE: begin
            if (req_bus.valid) begin
               state_in = needs_scan ? arc_pkg::ST_SCAN : arc_pkg::ST_DONE;
            end
         end
         arc_pkg::ST_SCAN: begin
            if (last_step) begin
               state_in = arc_pkg::ST_DONE;
            end
         end
         arc_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               state_in = arc_pkg::ST_IDLE;
            end
         end
         default: state_in = arc_pkg::ST_IDLE;
      endcase
   end

   // ---- state outputs
   always_comb begin
      req_bus.ready   = 1'b0;
      rsp_load        = 1'b0;
      cell_ctl.rotate = 1'b0;
      cell_ctl.insert = 1'b0;
      unique case (state_ff)
         arc_pkg::ST_IDLE: req_bus.ready = 1'b1;
         arc_pkg::ST_SCAN: cell_ctl.rotate = 1'b1;
         arc_pkg::ST_DONE: begin
            rsp_load        = !rsp_valid_ff || rsp_bus.ready;
            cell_ctl.insert = rsp_load && do_insert;
         end
         default: ;
      endcase
   end

   assign req_accept = req_bus.valid && req_bus.ready;

   // ---- datapath next values
   always_comb begin
      step_in  = step_ff;
      hit_in   = hit_ff;
      count_in = count_ff;
      if (req_accept) begin
         step_in = '0;
         hit_in  = 1'b0;
      end else if (state_ff == arc_pkg::ST_SCAN) begin
         // back to zero after the last step, whatever the depth
         step_in = last_step ? '0 : step_ff + 1'b1;
         if (head_valid && head_match) begin
            hit_in = 1'b1;
         end
      end
      if (cell_ctl.insert) begin
         count_in = count_ff + 1'b1;
      end
   end

   // response word, built from the finished item
   always_comb begin
      rsp_word_in             = '0;
      rsp_word_in.entry_count = 5'(count_in);
      rsp_word_in.table_full  = do_drop;
      unique case (item_ff.mode)
         arc_pkg::MODE_RX: begin
            if ((item_ff.opcode == arc_pkg::ARP_OP_REQUEST) &&
                (item_ff.target_ip == own_ip_ff)) begin
               rsp_word_in.send_frame       = 1'b1;
               rsp_word_in.frame_dest_mac   = item_ff.sender_mac;
               rsp_word_in.frame_opcode     = arc_pkg::FRAME_OP_REPLY;
               rsp_word_in.frame_sender_mac = own_mac_ff;
               rsp_word_in.frame_sender_ip  = own_ip_ff;
               rsp_word_in.frame_target_mac = item_ff.sender_mac;
               rsp_word_in.frame_target_ip  = item_ff.sender_ip;
            end
         end
         arc_pkg::MODE_WHO_HAS: begin
            rsp_word_in.send_frame       = 1'b1;
            rsp_word_in.frame_dest_mac   = arc_pkg::MAC_BROADCAST;
            rsp_word_in.frame_opcode     = arc_pkg::FRAME_OP_REQUEST;
            rsp_word_in.frame_sender_mac = own_mac_ff;
            rsp_word_in.frame_sender_ip  = own_ip_ff;
            rsp_word_in.frame_target_ip  = item_ff.query_ip;
         end
         arc_pkg::MODE_LOOKUP, arc_pkg::MODE_READ: begin
            if (hit_ff) begin
               rsp_word_in.found     = 1'b1;
               rsp_word_in.found_mac = hit_entry_ff.mac;
               rsp_word_in.found_ip  = hit_entry_ff.ip;
            end
         end
         default: ;
      endcase
   end

   // ---- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= arc_pkg::ST_IDLE;
         step_ff      <= '0;
         hit_ff       <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         hit_ff   <= hit_in;
         count_ff <= count_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff <= req_bus.word;
      end
      if ((state_ff == arc_pkg::ST_SCAN) && head_valid && head_match) begin
         hit_entry_ff <= cells[0];
      end
      if (rsp_load) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.word  = rsp_word_ff;

   // ---- checks
   `ARC_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= arc_pkg::COUNT_W'(DEPTH), "entry count above table depth")
   `ARC_ASSERT_NEXT(a_accept_busy, clock, reset, req_accept, state_ff != arc_pkg::ST_IDLE, "accepted word did not start work")
   `ARC_ASSERT_NEXT(a_scan_end, clock, reset, (state_ff == arc_pkg::ST_SCAN) && last_step, (state_ff == arc_pkg::ST_DONE) && (step_ff == '0), "scan did not finish after a full turn")
   `ARC_ASSERT_NEXT(a_count_hold, clock, reset, !cell_ctl.insert, $stable(count_ff), "entry count changed without an insert")

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for arp_responder_cache: random and directed request words
// against a cycle-free shadow of the ARP cache, responses compared field by field.
// Depends on arc_pkg, arc_if.sv and the arp_responder_cache RTL.
module tb_top;

   localparam int PHASE_WORDS   = 500;                       // random words per config phase
   localparam int SETTLE_CYCLES = arc_pkg::TABLE_DEPTH + 8;  // longer than one cache scan
   localparam int DRAIN_LIMIT   = 200000;                    // cycles to wait for a phase
   localparam int HOLD_CYCLES   = 300;                       // long receiver back-off
   localparam int MAX_REPORTS   = 10;

   typedef enum int {SINK_STREAM, SINK_COIN, SINK_SLOW} sink_pattern_type;

   logic clock = 1'b0;
   logic reset;

   arc_req_if req_bus ();
   arc_rsp_if rsp_bus ();
   arc_csr_if csr_bus ();

   arp_responder_cache dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Shadow of the block: config registers and the address table, oldest
   // entry in slot 0. Updated on accepted words only.
   // ---------------------------------------------------------------------
   logic [arc_pkg::IP_W-1:0]  own_ip_reg  = '0;
   logic [arc_pkg::MAC_W-1:0] own_mac_reg = '0;
   logic [arc_pkg::IP_W-1:0]  table_ip  [arc_pkg::TABLE_DEPTH];
   logic [arc_pkg::MAC_W-1:0] table_mac [arc_pkg::TABLE_DEPTH];
   int                        table_count = 0;

   arc_pkg::req_word_type pending_words[$];       // generated, not yet driven
   arc_pkg::rsp_word_type awaited_responses[$];   // predicted, not yet seen

   // generator's own view: every IP it has offered in a reply
   logic [arc_pkg::IP_W-1:0] gen_ips[$];
   logic [arc_pkg::IP_W-1:0] gen_own_ip = '0;

   int n_offered = 0, n_accepted = 0, n_checked = 0, n_errors = 0;
   int n_frames = 0, n_hits = 0, n_inserts = 0, n_drops = 0, n_csr_writes = 0;

   // driver / receiver state
   int burst_left = 0, gap_left = 0;
   int pattern_left = 0, hold_left = 0;
   bit hold_off_request = 1'b0;
   sink_pattern_type rsp_pattern = SINK_STREAM;

   // Work out the response to one word and apply its side effects to the table.
   function automatic arc_pkg::rsp_word_type compute_arp_response(arc_pkg::req_word_type w);
      arc_pkg::rsp_word_type r;
      int slot;
      int pos;
      int i;
      r    = '0;
      slot = -1;
      case (w.mode)
         arc_pkg::MODE_RX: begin
            if (w.opcode == arc_pkg::ARP_OP_REPLY) begin
               for (i = 0; i < table_count; i++)
                  if (table_ip[i] == w.sender_ip) slot = i;
               // known IP: no refresh of the stored MAC
               if (slot < 0) begin
                  if (table_count < arc_pkg::TABLE_DEPTH) begin
                     table_ip[table_count]  = w.sender_ip;
                     table_mac[table_count] = w.sender_mac;
                     table_count++;
                     n_inserts++;
                  end else begin
                     // no eviction, the insert is dropped and flagged
                     r.table_full = 1'b1;
                     n_drops++;
                  end
               end
            end else if (w.opcode == arc_pkg::ARP_OP_REQUEST && w.target_ip == own_ip_reg) begin
               // answer with addresses swapped; other targets get no proxy reply
               r.send_frame       = 1'b1;
               r.frame_dest_mac   = w.sender_mac;
               r.frame_opcode     = arc_pkg::FRAME_OP_REPLY;
               r.frame_sender_mac = own_mac_reg;
               r.frame_sender_ip  = own_ip_reg;
               r.frame_target_mac = w.sender_mac;
               r.frame_target_ip  = w.sender_ip;
            end
         end
         arc_pkg::MODE_LOOKUP: begin
            for (i = 0; i < table_count; i++)
               if (table_ip[i] == w.query_ip) slot = i;
            if (slot >= 0) begin
               r.found     = 1'b1;
               r.found_mac = table_mac[slot];
               r.found_ip  = table_ip[slot];
            end
         end
         arc_pkg::MODE_WHO_HAS: begin
            r.send_frame       = 1'b1;
            r.frame_dest_mac   = arc_pkg::MAC_BROADCAST;
            r.frame_opcode     = arc_pkg::FRAME_OP_REQUEST;
            r.frame_sender_mac = own_mac_reg;
            r.frame_sender_ip  = own_ip_reg;
            r.frame_target_mac = '0;
            r.frame_target_ip  = w.query_ip;
         end
         arc_pkg::MODE_READ: begin
            // index 0 is the newest entry
            if (int'(w.entry_index) < table_count) begin
               pos         = table_count - 1 - int'(w.entry_index);
               r.found     = 1'b1;
               r.found_mac = table_mac[pos];
               r.found_ip  = table_ip[pos];
            end
         end
      endcase
      r.entry_count = 5'(table_count);
      if (r.send_frame) n_frames++;
      if (r.found) n_hits++;
      return r;
   endfunction

   task automatic note_failure(input string msg);
      n_errors++;
      if (n_errors <= MAX_REPORTS) $display("[tb] mismatch: %s", msg);
   endtask

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (got !== want)
         note_failure($sformatf("word %0d %s expected %h got %h", n_checked, name, want, got));
   endtask

   // ---------------------------------------------------------------------
   // Word generation
   // ---------------------------------------------------------------------
   function automatic logic [arc_pkg::MAC_W-1:0] rand_mac();
      logic [63:0] v;
      v = {$urandom, $urandom};
      return v[arc_pkg::MAC_W-1:0];
   endfunction

   // all fields random; the queue helpers then set the ones that matter
   function automatic arc_pkg::req_word_type rand_word();
      arc_pkg::req_word_type w;
      w.mode        = 2'($urandom);
      w.opcode      = 16'($urandom);
      w.sender_mac  = rand_mac();
      w.sender_ip   = $urandom;
      w.target_ip   = $urandom;
      w.query_ip    = $urandom;
      w.entry_index = 5'($urandom);
      return w;
   endfunction

   function automatic bit ip_known(logic [arc_pkg::IP_W-1:0] ip);
      foreach (gen_ips[i])
         if (gen_ips[i] == ip) return 1'b1;
      return 1'b0;
   endfunction

   function automatic logic [arc_pkg::IP_W-1:0] fresh_ip();
      logic [arc_pkg::IP_W-1:0] ip;
      do ip = $urandom; while (ip_known(ip));
      gen_ips.push_back(ip);
      return ip;
   endfunction

   function automatic logic [arc_pkg::IP_W-1:0] known_ip();
      return gen_ips[$urandom_range(0, gen_ips.size() - 1)];
   endfunction

   function automatic void queue_rx(logic [15:0] op, logic [arc_pkg::MAC_W-1:0] smac,
                                    logic [arc_pkg::IP_W-1:0] sip,
                                    logic [arc_pkg::IP_W-1:0] tip);
      arc_pkg::req_word_type w;
      w            = rand_word();
      w.mode       = arc_pkg::MODE_RX;
      w.opcode     = op;
      w.sender_mac = smac;
      w.sender_ip  = sip;
      w.target_ip  = tip;
      pending_words.push_back(w);
   endfunction

   function automatic void queue_query(logic [1:0] mode, logic [arc_pkg::IP_W-1:0] ip,
                                       logic [arc_pkg::IDX_W-1:0] idx);
      arc_pkg::req_word_type w;
      w             = rand_word();
      w.mode        = mode;
      w.query_ip    = ip;
      w.entry_index = idx;
      pending_words.push_back(w);
   endfunction

   // Mostly well-formed traffic: replies that fill the cache slowly, requests
   // aimed at us, lookups of known IPs and in-range reads, plus some noise.
   function automatic void queue_random_word();
      int pick;
      int sub;
      logic [15:0] op;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         sub = $urandom_range(0, 9);
         if (sub < 6) begin
            if (gen_ips.size() == 0 || $urandom_range(0, 19) == 0)
               queue_rx(arc_pkg::ARP_OP_REPLY, rand_mac(), fresh_ip(), $urandom);
            else
               queue_rx(arc_pkg::ARP_OP_REPLY, rand_mac(), known_ip(), $urandom);
         end else if (sub < 9) begin
            queue_rx(arc_pkg::ARP_OP_REQUEST, rand_mac(), $urandom,
                     ($urandom_range(0, 9) < 7) ? gen_own_ip : $urandom);
         end else begin
            op = 16'($urandom);
            if (op == arc_pkg::ARP_OP_REQUEST || op == arc_pkg::ARP_OP_REPLY) op = ~op;
            queue_rx(op, rand_mac(), $urandom, gen_own_ip);
         end
      end else if (pick < 60) begin
         queue_query(arc_pkg::MODE_LOOKUP,
                     (gen_ips.size() > 0 && $urandom_range(0, 9) < 7) ? known_ip() : $urandom,
                     5'($urandom));
      end else if (pick < 70) begin
         queue_query(arc_pkg::MODE_WHO_HAS, $urandom, 5'($urandom));
      end else begin
         queue_query(arc_pkg::MODE_READ, $urandom,
                     ($urandom_range(0, 3) != 0)
                        ? 5'($urandom_range(0, arc_pkg::TABLE_DEPTH))
                        : 5'($urandom));
      end
   endfunction

   // ---------------------------------------------------------------------
   // Driver: request words at the falling edge, in bursts with random gaps.
   // A word stays up until the monitor has seen it accepted.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (req_bus.valid && n_accepted < n_offered) begin
         // still waiting for ready
      end else if (gap_left > 0) begin
         gap_left--;
         req_bus.valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
         req_bus.valid <= 1'b1;
         req_bus.word  <= pending_words.pop_front();
         n_offered++;
         if (burst_left > 0) burst_left--;
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 16);
         end
      end else begin
         req_bus.valid <= 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: ready pattern switches at random intervals between always
   // ready, coin toss and mostly stalled. A long hold-off can be requested.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (hold_off_request) begin
            hold_left        = HOLD_CYCLES;
            hold_off_request = 1'b0;
         end
         if (pattern_left == 0) begin
            rsp_pattern  = sink_pattern_type'($urandom_range(0, 2));
            pattern_left = $urandom_range(32, 256);
         end else begin
            pattern_left--;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            case (rsp_pattern)
               SINK_STREAM: rsp_bus.ready <= 1'b1;
               SINK_COIN:   rsp_bus.ready <= 1'($urandom_range(0, 1));
               default:     rsp_bus.ready <= ($urandom_range(0, 7) == 0);
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: all three handshakes sampled at the rising edge. Register
   // writes update the shadow config, accepted requests are predicted and
   // queued, accepted responses are checked against the oldest prediction.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      arc_pkg::rsp_word_type want;
      arc_pkg::rsp_word_type got;
      if (!reset) begin
         if (csr_bus.valid && csr_bus.ready) begin
            if (csr_bus.word.index == arc_pkg::CSR_OWN_IP)
               own_ip_reg = csr_bus.word.data[arc_pkg::IP_W-1:0];
            else if (csr_bus.word.index == arc_pkg::CSR_OWN_MAC)
               own_mac_reg = csr_bus.word.data;
            n_csr_writes++;
         end
         if (req_bus.valid && req_bus.ready) begin
            awaited_responses.push_back(compute_arp_response(req_bus.word));
            n_accepted++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = rsp_bus.word;
            if (awaited_responses.size() == 0) begin
               note_failure($sformatf("response word with nothing pending: %h", got));
            end else begin
               want = awaited_responses.pop_front();
               compare_field("send_frame", 64'(want.send_frame), 64'(got.send_frame));
               compare_field("frame_dest_mac", 64'(want.frame_dest_mac),
                             64'(got.frame_dest_mac));
               compare_field("frame_opcode", 64'(want.frame_opcode), 64'(got.frame_opcode));
               compare_field("frame_sender_mac", 64'(want.frame_sender_mac),
                             64'(got.frame_sender_mac));
               compare_field("frame_sender_ip", 64'(want.frame_sender_ip),
                             64'(got.frame_sender_ip));
               compare_field("frame_target_mac", 64'(want.frame_target_mac),
                             64'(got.frame_target_mac));
               compare_field("frame_target_ip", 64'(want.frame_target_ip),
                             64'(got.frame_target_ip));
               compare_field("found", 64'(want.found), 64'(got.found));
               compare_field("found_mac", 64'(want.found_mac), 64'(got.found_mac));
               compare_field("found_ip", 64'(want.found_ip), 64'(got.found_ip));
               compare_field("entry_count", 64'(want.entry_count), 64'(got.entry_count));
               compare_field("table_full", 64'(want.table_full), 64'(got.table_full));
               n_checked++;
            end
         end
      end
   end

   // Register write, only issued while the block is idle.
   task automatic write_csr(input logic idx, input logic [arc_pkg::MAC_W-1:0] data);
      @(negedge clock);
      csr_bus.valid      <= 1'b1;
      csr_bus.word.index <= idx;
      csr_bus.word.data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // Sender pause: everything driven, accepted and answered, then a settle
   // wait of SETTLE_CYCLES so a scan in flight is surely over.
   task automatic drain_block();
      int waited;
      waited = 0;
      while ((pending_words.size() > 0 || n_accepted < n_offered ||
              awaited_responses.size() > 0) && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Sequence: reset, directed words at the reset config, directed words at
   // a set config, then four random phases with their own own_ip/own_mac.
   // ---------------------------------------------------------------------
   initial begin
      logic [arc_pkg::IP_W-1:0]  ph_ip;
      logic [arc_pkg::MAC_W-1:0] ph_mac;
      int p;
      int k;
      reset         = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.word  = '0;
      csr_bus.valid = 1'b0;
      csr_bus.word  = '0;
      rsp_bus.ready = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset config: own_ip and own_mac are both zero, table is empty
      queue_query(arc_pkg::MODE_WHO_HAS, '0, '0);
      queue_rx(arc_pkg::ARP_OP_REQUEST, '1, '1, '0);     // request for IP 0 is ours
      queue_query(arc_pkg::MODE_READ, '0, 5'd0);         // empty table
      queue_query(arc_pkg::MODE_LOOKUP, '0, '0);
      drain_block();

      gen_own_ip = 32'hC0A8_0A01;
      write_csr(arc_pkg::CSR_OWN_IP, {16'hBEEF, gen_own_ip});
      write_csr(arc_pkg::CSR_OWN_MAC, 48'h02_00_5E_10_20_30);

      // inserts at the IP extremes, one duplicate that must not refresh
      gen_ips.push_back('0);
      gen_ips.push_back('1);
      queue_rx(arc_pkg::ARP_OP_REPLY, '1, '0, $urandom);
      queue_rx(arc_pkg::ARP_OP_REPLY, '0, '1, $urandom);
      queue_rx(arc_pkg::ARP_OP_REPLY, rand_mac(), fresh_ip(), $urandom);
      queue_rx(arc_pkg::ARP_OP_REPLY, 48'h0123_4567_89AB, '0, $urandom);
      queue_query(arc_pkg::MODE_LOOKUP, '0, '0);
      queue_query(arc_pkg::MODE_LOOKUP, '1, '0);
      queue_query(arc_pkg::MODE_LOOKUP, 32'h0A00_0001, '0);   // miss
      queue_query(arc_pkg::MODE_READ, '0, 5'd0);
      queue_query(arc_pkg::MODE_READ, '0, 5'd1);
      queue_query(arc_pkg::MODE_READ, '0, 5'd2);
      queue_query(arc_pkg::MODE_READ, '0, 5'd3);              // first index past the end
      queue_query(arc_pkg::MODE_READ, '0, 5'd31);
      queue_rx(arc_pkg::ARP_OP_REQUEST, rand_mac(), $urandom, gen_own_ip);
      queue_rx(arc_pkg::ARP_OP_REQUEST, rand_mac(), $urandom,
               gen_own_ip ^ 32'h1);                           // other host
      queue_rx(16'h0000, rand_mac(), $urandom, gen_own_ip);   // unknown opcodes
      queue_rx(16'h0003, rand_mac(), $urandom, gen_own_ip);
      queue_rx(16'hFFFF, rand_mac(), $urandom, gen_own_ip);
      queue_query(arc_pkg::MODE_WHO_HAS, '1, '1);
      drain_block();

      for (p = 0; p < 4; p++) begin
         case (p)
            0:       begin ph_ip = '1; ph_mac = '1; end
            1:       begin ph_ip = '0; ph_mac = '0; end
            default: begin ph_ip = $urandom; ph_mac = rand_mac(); end
         endcase
         if (p % 2 == 1) begin
            write_csr(arc_pkg::CSR_OWN_MAC, ph_mac);
            write_csr(arc_pkg::CSR_OWN_IP, {16'($urandom), ph_ip});
         end else begin
            write_csr(arc_pkg::CSR_OWN_IP, {16'($urandom), ph_ip});
            write_csr(arc_pkg::CSR_OWN_MAC, ph_mac);
         end
         gen_own_ip = ph_ip;
         // last phase: make sure the table overflows a few times
         if (p == 3)
            while (gen_ips.size() < arc_pkg::TABLE_DEPTH + 3)
               queue_rx(arc_pkg::ARP_OP_REPLY, rand_mac(), fresh_ip(), $urandom);
         for (k = 0; k < PHASE_WORDS; k++) queue_random_word();
         // receiver backs off hard while the sender keeps offering
         if (p == 1) hold_off_request = 1'b1;
         drain_block();
      end

      if (awaited_responses.size() != 0 || n_accepted != n_offered)
         note_failure($sformatf("%0d responses never arrived, %0d words not accepted",
                                awaited_responses.size(), n_offered - n_accepted));

      $display("[tb] summary: %0d words checked, %0d frames, %0d hits, %0d inserts, %0d drops",
               n_checked, n_frames, n_hits, n_inserts, n_drops);
      $display("[tb] summary: %0d register writes, %0d errors", n_csr_writes, n_errors);
      if (n_errors == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

   // hard stop, far beyond the slowest legal run
   initial begin
      #10_000_000;
      $display("[tb] timeout");
      $display("tb_top NOT OK");
      $finish;
   end

endmodule

### filelist.f
+incdir+rtl
rtl/arc_pkg.sv
rtl/arc_if.sv
rtl/arc_cell.sv
rtl/arp_responder_cache.sv
bench/tb_top.sv
